### rtl/ahps_pkg.sv
// shared types, codes and constants of the ata pio host sequencer
package ahps_pkg;

    localparam int WORDS_PER_SECTOR  = 256;
    localparam int WIDX_W            = $clog2(WORDS_PER_SECTOR + 1);
    localparam int DELAY_READS_DEF   = 4;
    localparam int POLL_W            = 17;
    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 17'd100000;
    localparam int MAX_RES           = 8;
    localparam int LEN_W             = $clog2(MAX_RES + 1);
    localparam logic [47:0] LBA28_MAX = 48'h0000_0FFF_FFFF;

    // input modes
    localparam logic [2:0] MODE_IDENT = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_RESP  = 3'd3;
    localparam logic [2:0] MODE_WORD  = 3'd4;

    // task file registers
    localparam logic [3:0] REG_DATA   = 4'd0;
    localparam logic [3:0] REG_SECCNT = 4'd2;
    localparam logic [3:0] REG_LBA0   = 4'd3;
    localparam logic [3:0] REG_LBA1   = 4'd4;
    localparam logic [3:0] REG_LBA2   = 4'd5;
    localparam logic [3:0] REG_DEV    = 4'd6;
    localparam logic [3:0] REG_CMD    = 4'd7;
    localparam logic [3:0] REG_ALT    = 4'd8;

    localparam logic [7:0] DEV_IDENT    = 8'hA0;
    localparam logic [7:0] DEV_LBA      = 8'hE0;
    localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] CMD_FLUSH    = 8'hE7;
    localparam logic [7:0] ST_ERR       = 8'h01;
    localparam logic [7:0] ST_DRQ       = 8'h08;
    localparam logic [7:0] ST_DF        = 8'h20;
    localparam logic [7:0] ST_BSY       = 8'h80;

    localparam logic [8:0] IDW_CAP28_LO = 9'd60;
    localparam logic [8:0] IDW_CAP28_HI = 9'd61;
    localparam logic [8:0] IDW_CAP48_0  = 9'd100;
    localparam logic [8:0] IDW_CAP48_3  = 9'd103;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ID_STATUS, PH_ID_LBA1, PH_ID_LBA2, PH_DLY_ID, PH_POLL_ID,
        PH_ID_DATA, PH_DLY_XFER, PH_POLL_XFER, PH_RD_DATA, PH_WR_DATA,
        PH_DLY_FLUSH, PH_POLL_FLUSH
    } t_phase;

    typedef enum logic [2:0] {
        ACT_WB, ACT_WW, ACT_RB, ACT_RW, ACT_HOST, ACT_REQ, ACT_DONE
    } t_action;

    typedef enum logic [2:0] {
        M_NONE, M_ID_START, M_BEGIN, M_DONE, M_RB, M_RW, M_REQ, M_FLUSH
    } t_main;

    typedef enum logic [1:0] {PRE_NONE, PRE_HOST, PRE_WW} t_pre;

    typedef struct packed {
        t_pre        pre;
        logic [15:0] pre_word;
        t_main       main;
        logic [3:0]  rb_reg;
        logic        ok;
    } t_plan;

    typedef struct packed {
        t_action     action;
        logic [3:0]  reg_sel;
        logic [15:0] bus_value;
        logic [15:0] host_word;
        logic        success;
        logic [63:0] capacity;
    } t_res;

    function automatic t_res mk_res(t_action a, logic [3:0] r, logic [15:0] v,
                                    logic [15:0] h);
        t_res x;
        x.action    = a;
        x.reg_sel   = r;
        x.bus_value = v;
        x.host_word = h;
        x.success   = 1'b0;
        x.capacity  = '0;
        return x;
    endfunction

endpackage

### rtl/ata_pio_host_sequencer.sv
// top level of the ata pio host sequencer
// usage:
//  - slave stream carries requests (identify, read, write), device read replies
//    and host write words; tuser holds the mode, tdata the lba, count and words
//  - master stream carries the transactions this causes: task-file writes and
//    reads, words to the host, word requests and a completion; tlast marks the
//    final transaction caused by one input item
//  - the user must write poll_limit through i_cfg_wr_en/i_cfg_wr_data only while
//    idle; the block itself does not enforce this
// path: an accepted item is registered, then stepped into the result line once
//  the line can load; throughput: one transaction per cycle on the master side
//  while the receiver is ready; an item of n transactions (n is 0 to 8) holds the
//  line until all are taken, so single-transaction items flow at one per cycle
// stall: a stalled receiver holds the result line; the input register then
//  fills and tready drops until the line drains
// reset: synchronous active low; the sequencer returns to idle with no disk
//  present, zero capacity and poll_limit at 100000
module ata_pio_host_sequencer import ahps_pkg::*; #(
    parameter int DELAY_READS = DELAY_READS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [111:0]      i_s_axis_tdata,   // lba, count, bus_data, write_word
    input  logic [2:0]        i_s_axis_tuser,   // mode
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [103:0]      o_m_axis_tdata,   // reg_select, bus_value, host_word,
                                                // success, capacity, zero pad
    output logic [2:0]        o_m_axis_tuser,   // action
    output logic              o_m_axis_tlast,
    input  logic              i_cfg_wr_en,
    input  logic [POLL_W-1:0] i_cfg_wr_data     // poll_limit
);

    // input register
    logic          r_in_valid;
    logic [111:0]  r_in_data;
    logic [2:0]    r_in_mode;
    logic [POLL_W-1:0] r_poll_limit;

    logic              can_load;
    logic              go;
    t_res              list [MAX_RES];
    logic [LEN_W-1:0]  len;
    t_res              head;

    assign go              = r_in_valid && can_load;
    assign o_s_axis_tready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // payload taken on each transaction, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_mode <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_poll_limit <= i_cfg_wr_data;
        end
    end

    ahps_step #(.DELAY_READS(DELAY_READS)) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_mode       (r_in_mode),
        .i_lba        (r_in_data[47:0]),
        .i_count      (r_in_data[79:48]),
        .i_bus_data   (r_in_data[95:80]),
        .i_write_word (r_in_data[111:96]),
        .i_poll_limit (r_poll_limit),
        .o_list       (list),
        .o_len        (len)
    );

    ahps_rbuf u_rbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (go),
        .i_list     (list),
        .i_len      (len),
        .i_ready    (i_m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .o_last     (o_m_axis_tlast),
        .o_head     (head)
    );

    assign o_m_axis_tuser = head.action;
    assign o_m_axis_tdata = {3'd0, head.capacity, head.success, head.host_word,
                             head.bus_value, head.reg_sel};

endmodule

### rtl/ahps_step.sv
// sequencer state and single-pass step that builds one item's transaction list
module ahps_step import ahps_pkg::*; #(
    parameter int DELAY_READS = DELAY_READS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [2:0]        i_mode,
    input  logic [47:0]       i_lba,
    input  logic [31:0]       i_count,
    input  logic [15:0]       i_bus_data,
    input  logic [15:0]       i_write_word,
    input  logic [POLL_W-1:0] i_poll_limit,
    output t_res              o_list [MAX_RES],
    output logic [LEN_W-1:0]  o_len
);

    localparam int DW = $clog2(DELAY_READS + 1);

    t_phase            r_phase, n_phase;
    logic              r_present, n_present;
    logic [63:0]       r_cap, n_cap;
    logic [27:0]       r_cur, n_cur;
    logic [31:0]       r_left, n_left;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic [POLL_W-1:0] r_spin, n_spin;
    logic [DW-1:0]     r_dly, n_dly;
    logic              r_wr, n_wr;
    logic [31:0]       r_c28, n_c28;
    logic [63:0]       r_c48, n_c48;
    t_plan             plan;

    logic [7:0]        b;
    logic [WIDX_W-1:0] widx_inc;
    logic              sect_end;
    logic [31:0]       left_dec;
    logic              refuse;

    assign b        = i_bus_data[7:0];
    assign widx_inc = r_widx + 1'b1;
    assign sect_end = (widx_inc == WIDX_W'(WORDS_PER_SECTOR));
    assign left_dec = r_left - 32'd1;
    assign refuse   = !r_present || (i_count == '0)
                    || (({16'd0, i_lba} + {32'd0, i_count}) > r_cap)
                    || (i_lba > LBA28_MAX);

    // next state and plan of results
    always_comb begin
        logic [63:0] c48;
        logic [5:0]  sh;
        c48       = r_c48;
        sh        = '0;
        n_phase   = r_phase;
        n_present = r_present;
        n_cap     = r_cap;
        n_cur     = r_cur;
        n_left    = r_left;
        n_widx    = r_widx;
        n_spin    = r_spin;
        n_dly     = r_dly;
        n_wr      = r_wr;
        n_c28     = r_c28;
        n_c48     = r_c48;
        plan      = '{pre: PRE_NONE, pre_word: '0, main: M_NONE, rb_reg: REG_DATA,
                      ok: 1'b0};

        if (i_mode == MODE_IDENT && r_phase == PH_IDLE) begin
            n_present = 1'b0;
            n_cap     = '0;
            n_phase   = PH_ID_STATUS;
            plan.main = M_ID_START;
        end else if ((i_mode == MODE_READ || i_mode == MODE_WRITE) && r_phase == PH_IDLE) begin
            if (refuse) begin
                plan.main = M_DONE;
            end else begin
                n_wr      = (i_mode == MODE_WRITE);
                n_cur     = i_lba[27:0];
                n_left    = i_count;
                n_phase   = PH_DLY_XFER;
                n_dly     = DW'(1);
                plan.main = M_BEGIN;
            end
        end else if (i_mode == MODE_RESP) begin
            unique case (r_phase)
                PH_ID_STATUS: begin
                    if (b == 8'h00 || b == 8'hFF) begin
                        plan.main = M_DONE;
                        n_phase   = PH_IDLE;
                    end else begin
                        n_phase     = PH_ID_LBA1;
                        plan.main   = M_RB;
                        plan.rb_reg = REG_LBA1;
                    end
                end
                PH_ID_LBA1, PH_ID_LBA2: begin
                    if (b != 8'h00) begin
                        plan.main = M_DONE;
                        n_phase   = PH_IDLE;
                    end else if (r_phase == PH_ID_LBA1) begin
                        n_phase     = PH_ID_LBA2;
                        plan.main   = M_RB;
                        plan.rb_reg = REG_LBA2;
                    end else begin
                        n_phase     = PH_DLY_ID;
                        n_dly       = DW'(1);
                        plan.main   = M_RB;
                        plan.rb_reg = REG_ALT;
                    end
                end
                PH_DLY_ID, PH_DLY_XFER, PH_DLY_FLUSH: begin
                    if (r_dly < DW'(DELAY_READS)) begin
                        n_dly       = r_dly + 1'b1;
                        plan.main   = M_RB;
                        plan.rb_reg = REG_ALT;
                    end else if (i_poll_limit == '0) begin
                        plan.main = M_DONE;
                        n_phase   = PH_IDLE;
                    end else begin
                        unique case (r_phase)
                            PH_DLY_ID:   n_phase = PH_POLL_ID;
                            PH_DLY_XFER: n_phase = PH_POLL_XFER;
                            default:     n_phase = PH_POLL_FLUSH;
                        endcase
                        n_spin      = POLL_W'(1);
                        plan.main   = M_RB;
                        plan.rb_reg = REG_CMD;
                    end
                end
                PH_POLL_ID, PH_POLL_XFER, PH_POLL_FLUSH: begin
                    priority if ((b & ST_BSY) == 8'h00 && (b & (ST_ERR | ST_DF)) != 8'h00) begin
                        plan.main = M_DONE;
                        n_phase   = PH_IDLE;
                    end else if ((b & ST_BSY) == 8'h00
                                 && (r_phase == PH_POLL_FLUSH || (b & ST_DRQ) != 8'h00)) begin
                        n_widx = '0;
                        unique case (r_phase)
                            PH_POLL_ID: begin
                                n_c28     = '0;
                                n_c48     = '0;
                                n_phase   = PH_ID_DATA;
                                plan.main = M_RW;
                            end
                            PH_POLL_XFER: begin
                                n_phase   = r_wr ? PH_WR_DATA : PH_RD_DATA;
                                plan.main = r_wr ? M_REQ : M_RW;
                            end
                            default: begin
                                n_left = left_dec;
                                n_cur  = r_cur + 28'd1;
                                if (left_dec == '0) begin
                                    plan.main = M_DONE;
                                    plan.ok   = 1'b1;
                                    n_phase   = PH_IDLE;
                                end else begin
                                    plan.main = M_BEGIN;
                                    n_phase   = PH_DLY_XFER;
                                    n_dly     = DW'(1);
                                end
                            end
                        endcase
                    end else if (r_spin >= i_poll_limit) begin
                        plan.main = M_DONE;
                        n_phase   = PH_IDLE;
                    end else begin
                        n_spin      = r_spin + 1'b1;
                        plan.main   = M_RB;
                        plan.rb_reg = REG_CMD;
                    end
                end
                PH_ID_DATA: begin
                    if (r_widx == IDW_CAP28_LO) begin
                        n_c28[15:0] = i_bus_data;
                    end else if (r_widx == IDW_CAP28_HI) begin
                        n_c28[31:16] = i_bus_data;
                    end else if (r_widx >= IDW_CAP48_0 && r_widx <= IDW_CAP48_3) begin
                        sh  = 6'({2'(r_widx - IDW_CAP48_0), 4'd0});
                        c48 = (r_c48 & ~(64'hFFFF << sh)) | ({48'd0, i_bus_data} << sh);
                        n_c48 = c48;
                    end
                    n_widx = widx_inc;
                    if (sect_end) begin
                        n_cap     = (n_c48 != '0) ? n_c48 : {32'd0, n_c28};
                        n_present = (n_cap != '0);
                        plan.main = M_DONE;
                        plan.ok   = n_present;
                        n_phase   = PH_IDLE;
                    end else begin
                        plan.main = M_RW;
                    end
                end
                PH_RD_DATA: begin
                    plan.pre      = PRE_HOST;
                    plan.pre_word = i_bus_data;
                    n_widx        = widx_inc;
                    if (sect_end) begin
                        n_left = left_dec;
                        n_cur  = r_cur + 28'd1;
                        if (left_dec == '0) begin
                            plan.main = M_DONE;
                            plan.ok   = 1'b1;
                            n_phase   = PH_IDLE;
                        end else begin
                            plan.main = M_BEGIN;
                            n_phase   = PH_DLY_XFER;
                            n_dly     = DW'(1);
                        end
                    end else begin
                        plan.main = M_RW;
                    end
                end
                default: ;
            endcase
        end else if (i_mode == MODE_WORD && r_phase == PH_WR_DATA) begin
            plan.pre      = PRE_WW;
            plan.pre_word = i_write_word;
            n_widx        = widx_inc;
            if (sect_end) begin
                plan.main = M_FLUSH;
                n_phase   = PH_DLY_FLUSH;
                n_dly     = DW'(1);
            end else begin
                plan.main = M_REQ;
            end
        end
    end

    // result list from the plan
    always_comb begin
        logic [LEN_W-1:0] k;
        t_res             d;
        k = '0;
        for (int i = 0; i < MAX_RES; i++) o_list[i] = '0;
        unique case (plan.pre)
            PRE_HOST: begin
                o_list[0] = mk_res(ACT_HOST, REG_DATA, 16'd0, plan.pre_word);
                k = LEN_W'(1);
            end
            PRE_WW: begin
                o_list[0] = mk_res(ACT_WW, REG_DATA, plan.pre_word, 16'd0);
                k = LEN_W'(1);
            end
            default: ;
        endcase
        unique case (plan.main)
            M_ID_START: begin
                o_list[0] = mk_res(ACT_WB, REG_DEV, {8'd0, DEV_IDENT}, 16'd0);
                o_list[1] = mk_res(ACT_WB, REG_SECCNT, 16'd0, 16'd0);
                o_list[2] = mk_res(ACT_WB, REG_LBA0, 16'd0, 16'd0);
                o_list[3] = mk_res(ACT_WB, REG_LBA1, 16'd0, 16'd0);
                o_list[4] = mk_res(ACT_WB, REG_LBA2, 16'd0, 16'd0);
                o_list[5] = mk_res(ACT_WB, REG_CMD, {8'd0, CMD_IDENTIFY}, 16'd0);
                o_list[6] = mk_res(ACT_RB, REG_CMD, 16'd0, 16'd0);
                k = LEN_W'(7);
            end
            M_BEGIN: begin
                o_list[k[2:0]] = mk_res(ACT_WB, REG_DEV,
                                        {8'd0, DEV_LBA | {4'd0, n_cur[27:24]}}, 16'd0);
                o_list[k[2:0] + 3'd1] = mk_res(ACT_WB, REG_SECCNT, 16'd1, 16'd0);
                o_list[k[2:0] + 3'd2] = mk_res(ACT_WB, REG_LBA0, {8'd0, n_cur[7:0]}, 16'd0);
                o_list[k[2:0] + 3'd3] = mk_res(ACT_WB, REG_LBA1, {8'd0, n_cur[15:8]}, 16'd0);
                o_list[k[2:0] + 3'd4] = mk_res(ACT_WB, REG_LBA2, {8'd0, n_cur[23:16]}, 16'd0);
                o_list[k[2:0] + 3'd5] = mk_res(ACT_WB, REG_CMD,
                                               {8'd0, n_wr ? CMD_WRITE : CMD_READ}, 16'd0);
                o_list[k[2:0] + 3'd6] = mk_res(ACT_RB, REG_ALT, 16'd0, 16'd0);
                k = k + LEN_W'(7);
            end
            M_DONE: begin
                d          = mk_res(ACT_DONE, REG_DATA, 16'd0, 16'd0);
                d.success  = plan.ok;
                d.capacity = n_cap;
                o_list[k[2:0]] = d;
                k = k + LEN_W'(1);
            end
            M_RB: begin
                o_list[k[2:0]] = mk_res(ACT_RB, plan.rb_reg, 16'd0, 16'd0);
                k = k + LEN_W'(1);
            end
            M_RW: begin
                o_list[k[2:0]] = mk_res(ACT_RW, REG_DATA, 16'd0, 16'd0);
                k = k + LEN_W'(1);
            end
            M_REQ: begin
                o_list[k[2:0]] = mk_res(ACT_REQ, REG_DATA, 16'd0, 16'd0);
                k = k + LEN_W'(1);
            end
            M_FLUSH: begin
                o_list[k[2:0]] = mk_res(ACT_WB, REG_CMD, {8'd0, CMD_FLUSH}, 16'd0);
                o_list[k[2:0] + 3'd1] = mk_res(ACT_RB, REG_ALT, 16'd0, 16'd0);
                k = k + LEN_W'(2);
            end
            default: ;
        endcase
        o_len = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_present <= 1'b0;
            r_cap     <= '0;
            r_cur     <= '0;
            r_left    <= '0;
            r_widx    <= '0;
            r_spin    <= '0;
            r_dly     <= '0;
            r_wr      <= 1'b0;
            r_c28     <= '0;
            r_c48     <= '0;
        end else if (i_go) begin
            r_phase   <= n_phase;
            r_present <= n_present;
            r_cap     <= n_cap;
            r_cur     <= n_cur;
            r_left    <= n_left;
            r_widx    <= n_widx;
            r_spin    <= n_spin;
            r_dly     <= n_dly;
            r_wr      <= n_wr;
            r_c28     <= n_c28;
            r_c48     <= n_c48;
        end
    end

endmodule

### rtl/ahps_rbuf.sv
// result line: holds one item's transaction list and shifts it out one per cycle while i_ready is high
module ahps_rbuf import ahps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_res             i_list [MAX_RES],
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_ready,
    output logic             o_can_load,
    output logic             o_valid,
    output logic             o_last,
    output t_res             o_head
);

    t_res             r_list [MAX_RES];
    logic [LEN_W-1:0] r_cnt;
    logic             pop;

    assign o_valid    = (r_cnt != '0);
    assign o_last     = (r_cnt == LEN_W'(1));
    assign o_head     = r_list[0];
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == '0) || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_len;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_list <= i_list;
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) r_list[i] <= r_list[i+1];
            r_list[MAX_RES-1] <= '0;
        end
    end

endmodule

### rtl/ahps_checker.sv
// port-level checks on the ata pio host sequencer, bound to the top level
module ahps_checker import ahps_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [103:0] o_m_axis_tdata,
    input logic [2:0]   o_m_axis_tuser,
    input logic         o_m_axis_tlast
);

    // reset empties the result line
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result line not empty after reset");

    // completion is always the final transaction of its item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ACT_DONE) |-> o_m_axis_tlast)
        else $error("completion not marked last");

    // success and capacity appear only with a completion
    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ACT_DONE) |-> (o_m_axis_tdata[100:36] == '0))
        else $error("status fields set outside completion");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled transaction changed");

endmodule

bind ata_pio_host_sequencer ahps_checker u_ahps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### verif/tb_ata_pio_host_sequencer.sv
// testbench for the ata pio host sequencer: plays the disk and the host, predicts every transaction
module tb_ata_pio_host_sequencer;
    import ahps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam logic [63:0] MASK28 = 64'h0FFF_FFFF;

    // expected transaction on the master side
    typedef struct {
        t_action     act;
        logic [3:0]  reg_sel;
        logic [15:0] bus_value;
        logic [15:0] host_word;
        logic        ok;
        logic [63:0] cap;
        logic        last;
    } t_expected;

    // model of the sequencer plus the queue of transactions still owed by the block
    class seq_scoreboard;
        t_expected   owed[$];
        int          errors;
        logic [16:0] poll_limit;
        t_phase      ph;
        logic        present;
        logic [63:0] capacity;
        logic [27:0] cur_sector;
        logic [31:0] sectors_left;
        int unsigned word_idx;
        logic [16:0] spins;
        int unsigned delays;
        logic        is_wr;
        logic [31:0] cap28;
        logic [63:0] cap48;
        t_expected   step[$];

        function new();
            errors       = 0;
            poll_limit   = POLL_LIMIT_RESET;
            ph           = PH_IDLE;
            present      = 1'b0;
            capacity     = '0;
            cur_sector   = '0;
            sectors_left = '0;
            word_idx     = 0;
            spins        = '0;
            delays       = 0;
            is_wr        = 1'b0;
            cap28        = '0;
            cap48        = '0;
        endfunction

        function void add(t_action a, logic [3:0] r, logic [15:0] v, logic [15:0] h,
                          logic ok = 1'b0, logic [63:0] c = '0);
            t_expected e;
            e.act = a; e.reg_sel = r; e.bus_value = v; e.host_word = h;
            e.ok = ok; e.cap = c; e.last = 1'b0;
            step.push_back(e);
        endfunction

        function void complete(logic ok);
            add(ACT_DONE, 4'd0, 16'd0, 16'd0, ok, capacity);
            ph = PH_IDLE;
        endfunction

        function void start_delay(t_phase p);
            delays = 1;
            ph = p;
            add(ACT_RB, REG_ALT, 16'd0, 16'd0);
        endfunction

        function void begin_sector();
            add(ACT_WB, REG_DEV, {8'd0, DEV_LBA | {4'd0, cur_sector[27:24]}}, 16'd0);
            add(ACT_WB, REG_SECCNT, 16'd1, 16'd0);
            add(ACT_WB, REG_LBA0, {8'd0, cur_sector[7:0]}, 16'd0);
            add(ACT_WB, REG_LBA1, {8'd0, cur_sector[15:8]}, 16'd0);
            add(ACT_WB, REG_LBA2, {8'd0, cur_sector[23:16]}, 16'd0);
            add(ACT_WB, REG_CMD, {8'd0, is_wr ? CMD_WRITE : CMD_READ}, 16'd0);
            start_delay(PH_DLY_XFER);
        endfunction

        function void sector_done();
            sectors_left = sectors_left - 1;
            cur_sector   = cur_sector + 1;   // wraps at 28 bits
            if (sectors_left == 0) begin
                complete(1'b1);
            end else begin
                begin_sector();
            end
        endfunction

        function void poll_passed();
            word_idx = 0;
            if (ph == PH_POLL_ID) begin
                cap28 = '0;
                cap48 = '0;
                ph = PH_ID_DATA;
                add(ACT_RW, REG_DATA, 16'd0, 16'd0);
            end else if (ph == PH_POLL_XFER) begin
                if (is_wr) begin
                    ph = PH_WR_DATA;
                    add(ACT_REQ, 4'd0, 16'd0, 16'd0);
                end else begin
                    ph = PH_RD_DATA;
                    add(ACT_RW, REG_DATA, 16'd0, 16'd0);
                end
            end else begin
                sector_done();
            end
        endfunction

        function void device_reply(logic [15:0] d);
            logic [7:0] b;
            b = d[7:0];
            case (ph)
                PH_ID_STATUS: begin
                    if (b == 8'h00 || b == 8'hFF) begin
                        complete(1'b0);
                    end else begin
                        ph = PH_ID_LBA1;
                        add(ACT_RB, REG_LBA1, 16'd0, 16'd0);
                    end
                end
                PH_ID_LBA1: begin
                    if (b != 0) begin
                        complete(1'b0);
                    end else begin
                        ph = PH_ID_LBA2;
                        add(ACT_RB, REG_LBA2, 16'd0, 16'd0);
                    end
                end
                PH_ID_LBA2: begin
                    if (b != 0) complete(1'b0);
                    else start_delay(PH_DLY_ID);
                end
                PH_DLY_ID, PH_DLY_XFER, PH_DLY_FLUSH: begin
                    if (delays < DELAY_READS_DEF) begin
                        delays++;
                        add(ACT_RB, REG_ALT, 16'd0, 16'd0);
                    end else if (poll_limit == 0) begin
                        complete(1'b0);
                    end else begin
                        ph = t_phase'(ph + 1);
                        spins = 1;
                        add(ACT_RB, REG_CMD, 16'd0, 16'd0);
                    end
                end
                PH_POLL_ID, PH_POLL_XFER, PH_POLL_FLUSH: begin
                    // busy first, then error or fault, then drq unless flushing
                    if (b & ST_BSY) begin
                        if (spins >= poll_limit) begin
                            complete(1'b0);
                        end else begin
                            spins++;
                            add(ACT_RB, REG_CMD, 16'd0, 16'd0);
                        end
                    end else if (b & (ST_ERR | ST_DF)) begin
                        complete(1'b0);
                    end else if (ph == PH_POLL_FLUSH || (b & ST_DRQ)) begin
                        poll_passed();
                    end else if (spins >= poll_limit) begin
                        complete(1'b0);
                    end else begin
                        spins++;
                        add(ACT_RB, REG_CMD, 16'd0, 16'd0);
                    end
                end
                PH_ID_DATA: begin
                    if (word_idx == IDW_CAP28_LO) cap28[15:0] = d;
                    else if (word_idx == IDW_CAP28_HI) cap28[31:16] = d;
                    else if (word_idx >= IDW_CAP48_0 && word_idx <= IDW_CAP48_3)
                        cap48[16*(word_idx-IDW_CAP48_0) +: 16] = d;
                    word_idx++;
                    if (word_idx >= WORDS_PER_SECTOR) begin
                        capacity = (cap48 != 0) ? cap48 : {32'd0, cap28};
                        present  = (capacity != 0);
                        complete(present);
                    end else begin
                        add(ACT_RW, REG_DATA, 16'd0, 16'd0);
                    end
                end
                PH_RD_DATA: begin
                    add(ACT_HOST, 4'd0, 16'd0, d);
                    word_idx++;
                    if (word_idx >= WORDS_PER_SECTOR) sector_done();
                    else add(ACT_RW, REG_DATA, 16'd0, 16'd0);
                end
                default: ;
            endcase
        endfunction

        // accepted input transaction: work out what it causes
        function void note_item(logic [2:0] mode, logic [47:0] lba, logic [31:0] cnt,
                                logic [15:0] bus, logic [15:0] hw);
            step.delete();
            if (mode == MODE_IDENT && ph == PH_IDLE) begin
                present  = 1'b0;
                capacity = '0;
                add(ACT_WB, REG_DEV, {8'd0, DEV_IDENT}, 16'd0);
                add(ACT_WB, REG_SECCNT, 16'd0, 16'd0);
                add(ACT_WB, REG_LBA0, 16'd0, 16'd0);
                add(ACT_WB, REG_LBA1, 16'd0, 16'd0);
                add(ACT_WB, REG_LBA2, 16'd0, 16'd0);
                add(ACT_WB, REG_CMD, {8'd0, CMD_IDENTIFY}, 16'd0);
                ph = PH_ID_STATUS;
                add(ACT_RB, REG_CMD, 16'd0, 16'd0);
            end else if ((mode == MODE_READ || mode == MODE_WRITE) && ph == PH_IDLE) begin
                if (!present || cnt == 0 || ({16'd0, lba} + {32'd0, cnt}) > capacity
                        || {16'd0, lba} > MASK28) begin
                    complete(1'b0);
                end else begin
                    is_wr        = (mode == MODE_WRITE);
                    cur_sector   = lba[27:0];
                    sectors_left = cnt;
                    begin_sector();
                end
            end else if (mode == MODE_RESP) begin
                device_reply(bus);
            end else if (mode == MODE_WORD && ph == PH_WR_DATA) begin
                add(ACT_WW, REG_DATA, hw, 16'd0);
                word_idx++;
                if (word_idx >= WORDS_PER_SECTOR) begin
                    add(ACT_WB, REG_CMD, {8'd0, CMD_FLUSH}, 16'd0);
                    start_delay(PH_DLY_FLUSH);
                end else begin
                    add(ACT_REQ, 4'd0, 16'd0, 16'd0);
                end
            end
            if (step.size() > 0) step[$].last = 1'b1;
            foreach (step[i]) owed.push_back(step[i]);
        endfunction

        function void mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
        endfunction

        // accepted output transaction: compare with the oldest expectation
        function void check_txn(t_action a, logic [3:0] r, logic [15:0] v, logic [15:0] h,
                                logic ok, logic [63:0] c, logic last);
            t_expected e;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual action %0d",
                         $time, a);
                return;
            end
            e = owed.pop_front();
            if (a !== e.act) mismatch("action", e.act, a);
            if (r !== e.reg_sel) mismatch("reg_select", e.reg_sel, r);
            if (v !== e.bus_value) mismatch("bus_value", e.bus_value, v);
            if (h !== e.host_word) mismatch("host_word", e.host_word, h);
            if (ok !== e.ok) mismatch("success", e.ok, ok);
            if (c !== e.cap) mismatch("capacity", e.cap, c);
            if (last !== e.last) mismatch("last", e.last, last);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [111:0]      i_s_axis_tdata;   // lba, count, bus_data, write_word
    logic [2:0]        i_s_axis_tuser;   // mode
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [103:0]      o_m_axis_tdata;   // reg_select, bus_value, host_word, success, capacity
    logic [2:0]        o_m_axis_tuser;   // action
    logic              o_m_axis_tlast;
    logic              i_cfg_wr_en;
    logic [POLL_W-1:0] i_cfg_wr_data;

    ata_pio_host_sequencer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    seq_scoreboard sb = new();

    // idling percentages for the two sides
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycles = 0;

    // how the simulated disk answers identify and polls
    logic [7:0]  id_status;
    logic [7:0]  id_sig1;
    logic [7:0]  id_sig2;
    logic [31:0] id_cap28;
    logic [63:0] id_cap48;
    int unsigned ready_pct;
    int unsigned noise_pct;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // cycle counter and watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_ata_pio_host_sequencer: errors");
            $finish;
        end
    end

    // result side: check every accepted transaction, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_txn(t_action'(o_m_axis_tuser), o_m_axis_tdata[3:0],
                             o_m_axis_tdata[19:4], o_m_axis_tdata[35:20],
                             o_m_axis_tdata[36], o_m_axis_tdata[100:37], o_m_axis_tlast);
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [47:0] rnd48();
        return {$urandom, $urandom};
    endfunction

    // one input transaction, sometimes with a random gap before it
    task automatic send_item(logic [2:0] mode, logic [47:0] lba, logic [31:0] cnt,
                             logic [15:0] bus, logic [15:0] hw);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= {hw, bus, cnt, lba};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_item(mode, lba, cnt, bus, hw);
    endtask

    // item the block should ignore: stray reply, stray word, busy request or unused mode
    task automatic send_noise();
        int unsigned pick;
        pick = $urandom_range(3);
        if (pick == 0 && sb.ph != PH_WR_DATA)
            send_item(MODE_WORD, rnd48(), $urandom, $urandom, $urandom);
        else if (pick == 1 && sb.ph != PH_IDLE)
            send_item(3'($urandom_range(2)), rnd48(), $urandom, $urandom, $urandom);
        else if (pick == 2 && (sb.ph == PH_IDLE || sb.ph == PH_WR_DATA))
            send_item(MODE_RESP, rnd48(), $urandom, $urandom, $urandom);
        else
            send_item(3'($urandom_range(7, 5)), rnd48(), $urandom, $urandom, $urandom);
    endtask

    // status byte for a poll, ready most of the time
    function automatic logic [7:0] poll_status(bit flush);
        int unsigned r;
        r = $urandom_range(99);
        if (r < ready_pct) return flush ? 8'h50 : 8'h58;
        case ($urandom_range(3))
            0: return ST_BSY | 8'($urandom);
            1: return 8'h40 | ST_ERR | 8'($urandom_range(1) ? ST_DRQ : 0);
            2: return 8'h40 | ST_DF;
            default: return flush ? (ST_BSY | 8'h50) : 8'h50;
        endcase
    endfunction

    // play the disk and the host until the running operation completes
    task automatic drive_to_idle();
        logic [15:0] d;
        while (sb.ph != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct) send_noise();
            d = $urandom;
            case (sb.ph)
                PH_ID_STATUS: d[7:0] = id_status;
                PH_ID_LBA1:   d[7:0] = id_sig1;
                PH_ID_LBA2:   d[7:0] = id_sig2;
                PH_POLL_ID, PH_POLL_XFER, PH_POLL_FLUSH:
                    d[7:0] = poll_status(sb.ph == PH_POLL_FLUSH);
                PH_ID_DATA: begin
                    if (sb.word_idx == IDW_CAP28_LO) d = id_cap28[15:0];
                    else if (sb.word_idx == IDW_CAP28_HI) d = id_cap28[31:16];
                    else if (sb.word_idx >= IDW_CAP48_0 && sb.word_idx <= IDW_CAP48_3)
                        d = id_cap48[16*(sb.word_idx-IDW_CAP48_0) +: 16];
                end
                default: ;
            endcase
            if (sb.ph == PH_WR_DATA)
                send_item(MODE_WORD, rnd48(), $urandom, $urandom, $urandom);
            else
                send_item(MODE_RESP, rnd48(), $urandom, d, $urandom);
        end
    endtask

    task automatic identify(logic [7:0] st, logic [7:0] s1, logic [7:0] s2,
                            logic [31:0] c28, logic [63:0] c48);
        id_status = st; id_sig1 = s1; id_sig2 = s2; id_cap28 = c28; id_cap48 = c48;
        send_item(MODE_IDENT, rnd48(), $urandom, $urandom, $urandom);
        drive_to_idle();
    endtask

    task automatic transfer(logic [2:0] mode, logic [47:0] lba, logic [31:0] cnt);
        send_item(mode, lba, cnt, $urandom, $urandom);
        drive_to_idle();
    endtask

    // wait until everything owed has arrived, then write poll_limit
    task automatic set_poll_limit(logic [16:0] v);
        i_s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.poll_limit = v;
    endtask

    // one random operation; mostly well-formed, some refused or malformed
    task automatic random_op();
        int unsigned k;
        logic [31:0] cnt;
        logic [63:0] hi;
        logic [47:0] lba;
        k = $urandom_range(99);
        if (k < 25 || !sb.present) begin
            case ($urandom_range(9))
                0: identify(8'($urandom_range(1) ? 8'h00 : 8'hFF), 0, 0, 100, 0);
                1: identify(8'h50, 8'($urandom_range(255, 1)), 0, 100, 0);
                2: identify(8'h50, 0, 0, $urandom_range(5000, 4), 64'h0000_2000_0000);
                3: identify(8'($urandom_range(254, 1)), 0, 0, $urandom, 0);
                default: identify(8'($urandom_range(254, 1)), 0, 0,
                                  $urandom_range(3000, 3), 0);
            endcase
        end else if (k < 32) begin
            transfer(3'($urandom_range(2, 1)), rnd48(), $urandom);
        end else begin
            cnt = ($urandom_range(9) < 8) ? 32'd1 : 32'($urandom_range(3, 2));
            if (sb.capacity < cnt) cnt = 1;
            hi = sb.capacity - cnt;
            if (hi > MASK28) hi = MASK28;
            lba = ($urandom_range(9) == 0) ? hi[47:0] : 48'($urandom_range(hi[31:0], 0));
            transfer(($urandom_range(1) ? MODE_READ : MODE_WRITE), lba, cnt);
        end
    endtask

    task automatic random_phase(int unsigned ops);
        repeat (ops) random_op();
    endtask

    initial begin
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        ready_pct       = 80;
        noise_pct       = 3;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: refusals, identify failures, capacity forms, wrap, a write
        set_poll_limit(17'd131071);
        transfer(MODE_READ, 48'd0, 32'd1);                    // no disk yet
        send_item(MODE_RESP, 48'hFFFF_FFFF_FFFF, '1, 16'hFFFF, 16'hFFFF);
        send_item(MODE_WORD, '0, '0, 16'h0000, 16'hFFFF);
        send_item(3'd7, '0, '0, 16'h0000, 16'h0000);
        identify(8'h00, 0, 0, 100, 0);
        identify(8'hFF, 0, 0, 100, 0);
        identify(8'h50, 8'h14, 0, 100, 0);
        identify(8'h50, 0, 8'hEB, 100, 0);
        identify(8'h50, 0, 0, 32'd0, 64'd0);                  // zero capacity
        identify(8'h50, 0, 0, 32'd77, 64'h0000_2000_0000);    // 48-bit count wins
        transfer(MODE_READ, 48'd5, 32'd0);
        transfer(MODE_READ, 48'h0000_1000_0000, 32'd1);       // beyond 28 bits
        transfer(MODE_WRITE, 48'h0000_0FFF_FFFF, 32'hFFFF_FFFF);
        transfer(MODE_READ, 48'h0000_0FFF_FFFF, 32'd2);       // address wraps
        transfer(MODE_WRITE, 48'd0, 32'd1);
        identify(8'h50, 0, 0, 32'hFFFF_FFFF, 64'd0);          // 28-bit count only
        transfer(MODE_WRITE, 48'h0000_0FFF_FFFE, 32'd1);

        // random: sender idles lightly, receiver heavily, short poll budget
        set_poll_limit(17'd3);
        ready_pct     = 65;
        send_idle_pct = 18;
        recv_idle_pct = 60;
        random_phase(35);

        // swapped idling, poll budget of one
        set_poll_limit(17'd1);
        send_idle_pct = 60;
        recv_idle_pct = 18;
        random_phase(35);

        // no idling; zero budget briefly, then the reset value
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_poll_limit(17'd0);
        random_phase(5);
        set_poll_limit(POLL_LIMIT_RESET);
        ready_pct = 80;
        random_phase(35);

        i_s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_ata_pio_host_sequencer: clean");
        end else begin
            $display("tb_ata_pio_host_sequencer: errors");
        end
        $finish;
    end

endmodule
